>>> hw/rtl/sha1_pkg.sv
package sha1_pkg;

	// One input beat: at most one message byte plus an end-of-message mark.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last;
	} sha1_in_t;

	// One result beat: the five digest words, word0 most significant.
	typedef struct packed {
		logic [31:0] digest_word0;
		logic [31:0] digest_word1;
		logic [31:0] digest_word2;
		logic [31:0] digest_word3;
		logic [31:0] digest_word4;
	} sha1_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} sha1_state_t;

	// Source of the byte shifted into the block buffer.
	typedef enum logic [1:0] {
		BSEL_IN,
		BSEL_MARK,
		BSEL_ZERO,
		BSEL_LEN
	} sha1_bsel_t;

	// Round group: selects the boolean function and the round constant.
	typedef enum logic [1:0] {
		PH_CH,
		PH_PAR1,
		PH_MAJ,
		PH_PAR2
	} sha1_phase_t;

	typedef struct packed {
		logic        load_byte;
		sha1_bsel_t  byte_sel;
		logic [2:0]  len_idx;
		logic        bits_add;
		logic        round_init;
		logic        round_step;
		sha1_phase_t phase;
		logic        chain_add;
		logic        emit;
	} sha1_cmd_t;

	typedef struct packed {
		logic out_free;
	} sha1_status_t;

	localparam int unsigned ROUNDS = 80;

	localparam logic [31:0] IV [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] K_CH   = 32'h5A827999;
	localparam logic [31:0] K_PAR1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
	localparam logic [31:0] K_PAR2 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

>>> hw/rtl/sha1_ctrl.sv
module sha1_ctrl import sha1_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic         byte_valid,
	input  logic         last,
	input  sha1_status_t status,
	output sha1_cmd_t    cmd
);

	localparam logic [5:0] FILL_FULL = 6'd63;
	localparam logic [5:0] FILL_LEN  = 6'd56;
	localparam logic [6:0] ROUND_END = 7'(ROUNDS - 1);

	sha1_state_t state_q, state_d;
	logic [5:0]  fill_q, fill_d;
	logic [6:0]  round_q, round_d;
	logic        pad_q, pad_d;
	logic        mark_q, mark_d;
	logic        len_q, len_d;
	logic        done_q, done_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			round_q <= '0;
			pad_q   <= 1'b0;
			mark_q  <= 1'b0;
			len_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			round_q <= round_d;
			pad_q   <= pad_d;
			mark_q  <= mark_d;
			len_q   <= len_d;
			done_q  <= done_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		fill_d   = fill_q;
		round_d  = round_q;
		pad_d    = pad_q;
		mark_d   = mark_q;
		len_d    = len_q;
		done_d   = done_q;
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);

		if (round_q inside {[7'd0:7'd19]}) begin
			cmd.phase = PH_CH;
		end else if (round_q inside {[7'd20:7'd39]}) begin
			cmd.phase = PH_PAR1;
		end else if (round_q inside {[7'd40:7'd59]}) begin
			cmd.phase = PH_MAJ;
		end else begin
			cmd.phase = PH_PAR2;
		end
		cmd.len_idx = fill_q[2:0];

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (byte_valid) begin
						cmd.load_byte = 1'b1;
						cmd.byte_sel  = BSEL_IN;
						cmd.bits_add  = 1'b1;
						fill_d        = fill_q + 6'd1;
					end
					if (last) begin
						pad_d   = 1'b1;
						state_d = ST_PAD;
					end
					// a full block always compresses first; padding resumes after
					if (byte_valid && fill_q == FILL_FULL) begin
						cmd.round_init = 1'b1;
						state_d        = ST_ROUND;
					end
				end
			end
			ST_PAD: begin
				cmd.load_byte = 1'b1;
				if (!mark_q) begin
					cmd.byte_sel = BSEL_MARK;
				end else if (len_q || fill_q == FILL_LEN) begin
					cmd.byte_sel = BSEL_LEN;
				end else begin
					cmd.byte_sel = BSEL_ZERO;
				end
				mark_d = 1'b1;
				if (mark_q && fill_q == FILL_LEN) begin
					len_d = 1'b1;
				end
				if (len_q && fill_q == FILL_FULL) begin
					done_d = 1'b1;
				end
				fill_d = fill_q + 6'd1;
				if (fill_q == FILL_FULL) begin
					cmd.round_init = 1'b1;
					state_d        = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round_step = 1'b1;
				round_d        = round_q + 7'd1;
				if (round_q == ROUND_END) begin
					round_d = '0;
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.chain_add = 1'b1;
				if (done_q) begin
					state_d = ST_EMIT;
				end else if (pad_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					pad_d    = 1'b0;
					mark_d   = 1'b0;
					len_d    = 1'b0;
					done_d   = 1'b0;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/sha1_dp.sv
module sha1_dp import sha1_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [7:0]   data_byte,
	input  sha1_cmd_t    cmd,
	output sha1_status_t status,
	output logic         out_valid,
	input  logic         out_stall,
	output sha1_out_t    out_data
);

	function automatic logic [31:0] rol(input logic [31:0] x, input logic [4:0] c);
		logic [63:0] d;
		d = {x, x} << c;
		return d[63:32];
	endfunction

	// Block buffer: bytes shift in at the bottom; during rounds it doubles as
	// the 16-word schedule window with word 0 at the top.
	logic [511:0] blk_q;
	logic [31:0]  ch_q [5];
	logic [31:0]  rw_q [5];
	logic [63:0]  bits_q;
	logic         out_valid_q;
	sha1_out_t    out_q;

	logic [7:0]  byte_in;
	logic [2:0]  len_sel;
	logic [31:0] w0, w2, w8, w13, w_next;
	logic [31:0] f_val, k_val, t_val;

	assign len_sel = 3'd7 - cmd.len_idx;

	always_comb begin
		case (cmd.byte_sel)
			BSEL_IN:   byte_in = data_byte;
			BSEL_MARK: byte_in = PAD_MARK;
			BSEL_LEN:  byte_in = bits_q[{len_sel, 3'b000} +: 8];
			default:   byte_in = 8'h00;
		endcase
	end

	assign w0     = blk_q[511:480];
	assign w2     = blk_q[447:416];
	assign w8     = blk_q[255:224];
	assign w13    = blk_q[95:64];
	assign w_next = rol(w13 ^ w8 ^ w2 ^ w0, 5'd1);

	always_comb begin
		case (cmd.phase)
			PH_CH: begin
				f_val = (rw_q[1] & rw_q[2]) | (~rw_q[1] & rw_q[3]);
				k_val = K_CH;
			end
			PH_PAR1: begin
				f_val = rw_q[1] ^ rw_q[2] ^ rw_q[3];
				k_val = K_PAR1;
			end
			PH_MAJ: begin
				f_val = (rw_q[1] & rw_q[2]) | (rw_q[1] & rw_q[3]) | (rw_q[2] & rw_q[3]);
				k_val = K_MAJ;
			end
			default: begin
				f_val = rw_q[1] ^ rw_q[2] ^ rw_q[3];
				k_val = K_PAR2;
			end
		endcase
	end

	assign t_val = rol(rw_q[0], 5'd5) + f_val + rw_q[4] + k_val + w0;

	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			blk_q <= {blk_q[503:0], byte_in};
		end else if (cmd.round_step) begin
			blk_q <= {blk_q[479:0], w_next};
		end
	end

	// Working variables load from the chain as the last byte of a block lands.
	always_ff @(posedge clk) begin
		if (cmd.round_init) begin
			for (int i = 0; i < 5; i++) begin
				rw_q[i] <= ch_q[i];
			end
		end else if (cmd.round_step) begin
			rw_q[0] <= t_val;
			rw_q[1] <= rw_q[0];
			rw_q[2] <= rol(rw_q[1], 5'd30);
			rw_q[3] <= rw_q[2];
			rw_q[4] <= rw_q[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) begin
				ch_q[i] <= IV[i];
			end
			bits_q <= '0;
		end else begin
			if (cmd.chain_add) begin
				for (int i = 0; i < 5; i++) begin
					ch_q[i] <= ch_q[i] + rw_q[i];
				end
			end else if (cmd.emit) begin
				for (int i = 0; i < 5; i++) begin
					ch_q[i] <= IV[i];
				end
			end
			if (cmd.emit) begin
				bits_q <= '0;
			end else if (cmd.bits_add) begin
				bits_q <= bits_q + 64'd8;
			end
		end
	end

	assign status.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.digest_word0 <= ch_q[0];
			out_q.digest_word1 <= ch_q[1];
			out_q.digest_word2 <= ch_q[2];
			out_q.digest_word3 <= ch_q[3];
			out_q.digest_word4 <= ch_q[4];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> hw/rtl/sha1_digest_engine.sv
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+-------------------------------------
// in        | input     | in_valid / in_stall   | in_data: data_byte, byte_valid, last
// out       | output    | out_valid / out_stall | out_data: digest_word0..digest_word4
//
// An input beat is taken while the controller is idle; the 64th byte of a block
// starts 80 rounds (one SHA-1 round per cycle), then folds the rounds into the chain.
// A last beat shifts in padding bytes up to the block end, runs one or two
// compressions, then loads the output register once it is free.
// Reset clears the controller, the bit count and the output valid and restores
// the initial chaining values; the block buffer is not cleared.
// in_stall is high whenever the controller is not idle; the output register
// holds a digest under out_stall while the next message is already hashed.
module sha1_digest_engine import sha1_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  sha1_in_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output sha1_out_t out_data
);

	sha1_cmd_t    cmd;
	sha1_status_t status;

	// Sequencer: byte intake, padding, round count and digest hand-off.
	sha1_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.byte_valid (in_data.byte_valid),
		.last       (in_data.last),
		.status     (status),
		.cmd        (cmd)
	);

	// Block buffer and schedule window, round unit, chain and output register.
	sha1_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (in_data.data_byte),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
